>>> sv/sfl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfl_pkg: shared types and constants of the serial frame loader
// Frame kinds, the controller states and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sfl_pkg;

	// frame kinds carried in the operation field
	localparam logic [1:0] OP_OPTION    = 2'd0;
	localparam logic [1:0] OP_REFERENCE = 2'd1;
	localparam logic [1:0] OP_PROGRAM   = 2'd2;

	// highest radio code that is served
	localparam logic [1:0] RADIO_LAST = 2'd2;

	// option register
	localparam int          OPTION_BITS  = 11;
	localparam logic [10:0] OPTION_RESET = 11'd1048;

	// decimal digit fields of a program request
	localparam int DIGIT_FIELDS = 5;
	localparam int DIGIT_W      = 4;
	localparam int DIG_CNT_W    = 3;
	// 5 digits of up to 15 each stay below 2^18
	localparam int ACC_W        = 18;

	// register map
	localparam logic REG_OPTION = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SEND,
		ST_STROBE
	} state_t;

	typedef struct packed {
		logic load;        // capture a new request
		logic conv;        // one decimal digit step
		logic load_prog;   // move the converted value into the shifter
		logic emit_bit;    // put the next data bit in the output register
		logic emit_strobe; // put the strobe in the output register
	} sfl_cmd_t;

	typedef struct packed {
		logic out_free;    // output register can take a result
		logic bits_last;   // shifter holds its last bit
		logic digits_last; // conversion is on its last digit
	} sfl_sts_t;

endpackage

>>> sv/sfl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfl_ctrl: frame sequencer
// Takes a request, steps the digit conversion for program frames, then
// sends the data bits and the closing strobe one result at a time.
// ----------------------------------------------------------------------------
module sfl_ctrl import sfl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] operation,
	input  logic [1:0] radio_select,
	input  sfl_sts_t   sts,
	output sfl_cmd_t   cmd
);

	state_t state_q;
	state_t state_d;
	logic   req_ok;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// unknown kinds and radios are dropped without results
	assign req_ok = (operation == OP_OPTION || operation == OP_REFERENCE ||
		operation == OP_PROGRAM) && (radio_select <= RADIO_LAST);

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && req_ok) begin
					cmd.load = 1'b1;
					state_d  = (operation == OP_PROGRAM) ? ST_CONV : ST_SEND;
				end
			end
			ST_CONV: begin
				cmd.conv = 1'b1;
				if (sts.digits_last) begin
					cmd.load_prog = 1'b1;
					state_d       = ST_SEND;
				end
			end
			ST_SEND: begin
				if (sts.out_free) begin
					cmd.emit_bit = 1'b1;
					if (sts.bits_last) begin
						state_d = ST_STROBE;
					end
				end
			end
			ST_STROBE: begin
				if (sts.out_free) begin
					cmd.emit_strobe = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef SYNTH
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_bit || cmd.emit_strobe) |-> sts.out_free)
		else $error("result issued while output register full");
	a_emit_one: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit_bit && cmd.emit_strobe))
		else $error("data bit and strobe issued together");
	a_strobe_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_bit && sts.bits_last) |=> (state_q == ST_STROBE))
		else $error("last data bit not followed by strobe");
	a_prog_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_prog |-> (cmd.conv && sts.digits_last))
		else $error("program value loaded before conversion finished");
`endif

endmodule

>>> sv/sfl_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfl_dp: frame datapath
// Decimal to binary accumulator, frame shifter with bit counter and the
// output register that holds one result until it is taken.
// ----------------------------------------------------------------------------
module sfl_dp import sfl_pkg::*; #(
	parameter int PROGRAM_BITS   = 17,
	parameter int REFERENCE_BITS = 12,
	parameter int PROGRAM_DIGITS = 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sfl_cmd_t               cmd,
	output sfl_sts_t               sts,
	input  logic [OPTION_BITS-1:0] option_word,
	input  logic [1:0]             operation,
	input  logic [1:0]             radio_select,
	input  logic [11:0]            reference_divider,
	input  logic [DIGIT_W-1:0]     digit_ten_thousands,
	input  logic [DIGIT_W-1:0]     digit_thousands,
	input  logic [DIGIT_W-1:0]     digit_hundreds,
	input  logic [DIGIT_W-1:0]     digit_tens,
	input  logic [DIGIT_W-1:0]     digit_units,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [1:0]             target_radio,
	output logic                   data_bit,
	output logic                   strobe_last
);

	localparam int USED_DIGITS = (PROGRAM_DIGITS < DIGIT_FIELDS) ? PROGRAM_DIGITS
		: DIGIT_FIELDS;
	localparam int MAX_A    = (PROGRAM_BITS > REFERENCE_BITS) ? PROGRAM_BITS
		: REFERENCE_BITS;
	localparam int MAX_BITS = (MAX_A > OPTION_BITS) ? MAX_A : OPTION_BITS;
	localparam int SH_W     = MAX_BITS + 2;
	localparam int CNT_W    = $clog2(SH_W + 1);
	localparam int DIGS_W   = DIGIT_FIELDS * DIGIT_W;

	localparam logic [CNT_W-1:0] CNT_OPT  = CNT_W'(OPTION_BITS + 2);
	localparam logic [CNT_W-1:0] CNT_REF  = CNT_W'(REFERENCE_BITS + 2);
	localparam logic [CNT_W-1:0] CNT_PROG = CNT_W'(PROGRAM_BITS + 2);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
	localparam logic [DIG_CNT_W-1:0] DIG_LAST = DIG_CNT_W'(USED_DIGITS - 1);

	localparam logic [SH_W-1:0] MASK_REF  = {SH_W{1'b1}} >> (SH_W - REFERENCE_BITS);
	localparam logic [SH_W-1:0] MASK_PROG = {SH_W{1'b1}} >> (SH_W - PROGRAM_BITS);
	// group codes in send order: reference 1,1 and program 1,0; option 0,0
	localparam logic [SH_W-1:0] TAIL_REF  = SH_W'(2'b11) << REFERENCE_BITS;
	localparam logic [SH_W-1:0] TAIL_PROG = SH_W'(2'b01) << PROGRAM_BITS;

	logic [SH_W-1:0]      sh_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [ACC_W-1:0]     acc_q;
	logic [ACC_W-1:0]     acc_next;
	logic [DIGS_W-1:0]    digits_q;
	logic [DIG_CNT_W-1:0] dig_q;
	logic [1:0]           radio_q;
	logic                 out_valid_q;
	logic [1:0]           out_radio_q;
	logic                 out_data_q;
	logic                 out_strobe_q;
	logic [SH_W-1:0]      sh_load;

	// one decimal step: acc * 10 + next digit
	assign acc_next = ACC_W'({acc_q, 3'b000}) + ACC_W'({acc_q, 1'b0})
		+ ACC_W'(digits_q[DIGS_W-1 -: DIGIT_W]);

	// initial shifter contents for option and reference frames
	always_comb begin
		if (operation == OP_REFERENCE) begin
			sh_load = (SH_W'(reference_divider) & MASK_REF) | TAIL_REF;
		end else begin
			sh_load = SH_W'(option_word);
		end
	end

	// request capture, conversion and shifting
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			radio_q  <= radio_select;
			acc_q    <= '0;
			dig_q    <= '0;
			digits_q <= {digit_ten_thousands, digit_thousands, digit_hundreds,
				digit_tens, digit_units};
			sh_q     <= sh_load;
			cnt_q    <= (operation == OP_REFERENCE) ? CNT_REF : CNT_OPT;
		end else if (cmd.conv) begin
			acc_q    <= acc_next;
			dig_q    <= dig_q + DIG_CNT_W'(1);
			digits_q <= digits_q << DIGIT_W;
			if (cmd.load_prog) begin
				sh_q  <= (SH_W'(acc_next) & MASK_PROG) | TAIL_PROG;
				cnt_q <= CNT_PROG;
			end
		end else if (cmd.emit_bit) begin
			sh_q  <= sh_q >> 1;
			cnt_q <= cnt_q - CNT_ONE;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_bit || cmd.emit_strobe) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit_bit || cmd.emit_strobe) begin
			out_radio_q  <= radio_q;
			out_data_q   <= cmd.emit_bit & sh_q[0];
			out_strobe_q <= cmd.emit_strobe;
		end
	end

	assign sts.out_free    = !out_valid_q || out_ready;
	assign sts.bits_last   = (cnt_q == CNT_ONE);
	assign sts.digits_last = (dig_q == DIG_LAST);

	assign out_valid    = out_valid_q;
	assign target_radio = out_radio_q;
	assign data_bit     = out_data_q;
	assign strobe_last  = out_strobe_q;

endmodule

>>> sv/pll_serial_frame_loader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pll_serial_frame_loader: three-wire frame loader for radio PLL synthesizers
// Turns one request into a run of clocked data bits and a closing strobe.
// ----------------------------------------------------------------------------
// Usage:
//  - request channel (in_valid/in_ready) takes one frame request at a time:
//    kind, target radio, reference divider and five decimal digits.
//    Requests with an unknown kind or radio are taken and dropped.
//  - result channel (out_valid/out_ready) gives one result per bit:
//    radio, data level, and a strobe flag set only on the last result.
//  - option frame: 11 option bits then 0,0; reference frame: divider then
//    1,1; program frame: digits as binary then 1,0; each closes with strobe.
//  - a program request runs PROGRAM_DIGITS digits (at most 5) through the
//    decimal-to-binary accumulator, one digit per cycle, before sending.
//  - the first result is valid once the sequencer state and then the output
//    register have been loaded; a program request converts its digits first.
//  - results then leave at one per cycle while out_ready is high.
//  - a new request is taken once the strobe sits in the output register.
//  - a stalled receiver holds the current result; the sequencer waits.
//  - reset empties the output register and reloads option_word with 1048.
//  - APB: option_word at address 0, written in the access phase.
// ----------------------------------------------------------------------------
module pll_serial_frame_loader import sfl_pkg::*; #(
	parameter int PROGRAM_BITS   = 17,
	parameter int REFERENCE_BITS = 12,
	parameter int PROGRAM_DIGITS = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// request channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic [1:0]         radio_select,
	input  logic [11:0]        reference_divider,
	input  logic [DIGIT_W-1:0] digit_ten_thousands,
	input  logic [DIGIT_W-1:0] digit_thousands,
	input  logic [DIGIT_W-1:0] digit_hundreds,
	input  logic [DIGIT_W-1:0] digit_tens,
	input  logic [DIGIT_W-1:0] digit_units,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         target_radio,
	output logic               data_bit,
	output logic               strobe_last
);

	logic [OPTION_BITS-1:0] option_q;
	logic                   cfg_wr;
	sfl_cmd_t               cmd;
	sfl_sts_t               sts;

	// option register write
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_OPTION);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			option_q <= OPTION_RESET;
		end else if (cfg_wr) begin
			option_q <= pwdata[OPTION_BITS-1:0];
		end
	end

	// register read
	assign prdata = (paddr[2] == REG_OPTION) ? 32'(option_q) : 32'd0;

	// sequencer
	sfl_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.radio_select (radio_select),
		.sts          (sts),
		.cmd          (cmd)
	);

	// datapath
	sfl_dp #(
		.PROGRAM_BITS   (PROGRAM_BITS),
		.REFERENCE_BITS (REFERENCE_BITS),
		.PROGRAM_DIGITS (PROGRAM_DIGITS)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.sts                 (sts),
		.option_word         (option_q),
		.operation           (operation),
		.radio_select        (radio_select),
		.reference_divider   (reference_divider),
		.digit_ten_thousands (digit_ten_thousands),
		.digit_thousands     (digit_thousands),
		.digit_hundreds      (digit_hundreds),
		.digit_tens          (digit_tens),
		.digit_units         (digit_units),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.target_radio        (target_radio),
		.data_bit            (data_bit),
		.strobe_last         (strobe_last)
	);

endmodule
